[hdl/slfc_pkg.sv]
// Shared constants, types and a helper function of the signal level filter chain.
`default_nettype none
package slfc_pkg;

    localparam int NUM_CHANNELS = 2;
    localparam int CH_W         = 1;
    localparam int SAMPLE_W     = 16;
    localparam int LEVEL_W      = 24;
    localparam int VAR_W        = 32;
    localparam int WEIGHT_W     = 17;
    localparam int CFG_IDX_W    = 8;
    localparam int CFG_DATA_W   = 32;
    localparam int MUL_A_W      = 18;
    localparam int MUL_B_W      = 34;
    localparam int MUL_P_W      = MUL_A_W + MUL_B_W;

    localparam logic [WEIGHT_W-1:0] ONE_Q16 = 17'd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE_KALMAN   = 8'd0,
        REG_ENABLE_LOWPASS  = 8'd1,
        REG_ENABLE_TWO_POLE = 8'd2,
        REG_PROCESS_NOISE   = 8'd3,
        REG_MEAS_NOISE      = 8'd4,
        REG_LOWPASS_ALPHA   = 8'd5,
        REG_TWO_POLE_ALPHA  = 8'd6
    } cfg_reg_t;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [LEVEL_W-1:0]  level_t;

    // Weights above one are treated as one.
    function automatic logic [WEIGHT_W-1:0] clamp_weight(input logic [WEIGHT_W-1:0] w);
        clamp_weight = (w > ONE_Q16) ? ONE_Q16 : w;
    endfunction

endpackage
`default_nettype wire

[hdl/slfc_in_if.sv]
// Input channel: one level sample and its channel bit per request.
`default_nettype none
interface slfc_in_if;
    logic                     valid;
    logic                     ready;
    slfc_pkg::sample_t        sample_level;
    logic [slfc_pkg::CH_W-1:0] channel;

    modport source (output valid, output sample_level, output channel, input ready);
    modport sink   (input valid, input sample_level, input channel, output ready);
endinterface
`default_nettype wire

[hdl/slfc_out_if.sv]
// Output channel: one filtered level per request.
`default_nettype none
interface slfc_out_if;
    logic              valid;
    logic              ready;
    slfc_pkg::sample_t filtered_level;

    modport source (output valid, output filtered_level, input ready);
    modport sink   (input valid, input filtered_level, output ready);
endinterface
`default_nettype wire

[hdl/slfc_mul.sv]
// Shared signed multiplier with a registered product.
`default_nettype none
module slfc_mul (
    input  wire logic                                 clk,
    input  wire logic signed [slfc_pkg::MUL_A_W-1:0] op_a,
    input  wire logic signed [slfc_pkg::MUL_B_W-1:0] op_b,
    output logic signed [slfc_pkg::MUL_P_W-1:0]      product
);

    logic signed [slfc_pkg::MUL_P_W-1:0] product_reg;

    always_ff @(posedge clk)
    begin
        product_reg <= op_a * op_b;
    end

    assign product = product_reg;

endmodule
`default_nettype wire

[hdl/signal_level_filter_chain.sv]
// Signal level filter chain: Kalman update, low-pass and three-tap smoother per channel.
// An accepted sample passes the enabled stages in order: Kalman, low-pass, smoother and the
// output register; the Kalman stage skips its division when its denominator is zero.
// A new sample is taken only in idle, after the last result has entered the output register.
// Reset clears all channel state to zero and loads the configuration defaults.
`default_nettype none
module signal_level_filter_chain (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    slfc_in_if.sink                                 samples,
    slfc_out_if.source                              levels,
    input  wire logic                               cfg_we,
    input  wire logic [slfc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [slfc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int LW = slfc_pkg::LEVEL_W;
    localparam int VW = slfc_pkg::VAR_W;
    localparam int WW = slfc_pkg::WEIGHT_W;
    localparam int PW = slfc_pkg::MUL_P_W;
    localparam int AW = 44;
    localparam int XW = 28;

    typedef enum logic [4:0] {
        ST_IDLE, ST_KPP, ST_KDEN, ST_KDIVI, ST_KDIV, ST_KM1, ST_KM2, ST_KM3,
        ST_LP1, ST_LP2, ST_SW1, ST_SW2, ST_SW3, ST_SA1, ST_SA2, ST_SA3, ST_OUT
    } state_t;

    state_t state_reg;

    logic          en_k_reg, en_lp_reg, en_tp_reg;
    logic [VW-1:0] q_reg, r_reg;
    logic [WW-1:0] lp_alpha_reg, tp_alpha_reg;

    slfc_pkg::level_t est_reg [slfc_pkg::NUM_CHANNELS];
    logic [VW-1:0]    p_reg   [slfc_pkg::NUM_CHANNELS];
    slfc_pkg::level_t y_reg   [slfc_pkg::NUM_CHANNELS];
    slfc_pkg::level_t x1_reg  [slfc_pkg::NUM_CHANNELS];
    slfc_pkg::level_t x2_reg  [slfc_pkg::NUM_CHANNELS];

    logic [slfc_pkg::CH_W-1:0] ch_reg;
    logic signed [XW-1:0]      v_reg;
    logic [VW-1:0]             pp_reg;
    logic [VW:0]               den_reg;
    logic [VW:0]               rem_reg;
    logic [WW-1:0]             k_reg;
    logic [3:0]                cnt_reg;
    logic [WW-1:0]             w1_reg, w2_reg;
    logic signed [AW-1:0]      acc_reg;
    logic                      out_valid_reg;
    slfc_pkg::sample_t         out_level_reg;

    logic signed [slfc_pkg::MUL_A_W-1:0] mul_a;
    logic signed [slfc_pkg::MUL_B_W-1:0] mul_b;
    logic signed [PW-1:0]                product;

    slfc_pkg::level_t cur_est, cur_y, cur_x1, cur_x2, v24;
    logic [VW:0]      pp_sum, den_sum;
    logic [VW+1:0]    rem_sh, rem_sub;
    logic             div_ge;
    logic signed [PW-1:0] prod_rnd;
    logic signed [PW-17:0] rnd16;
    logic [PW-1:0]    p_rnd;
    logic signed [LW:0] est_sum, y_sum;
    logic signed [LW:0] diff_est, diff_y;
    logic signed [AW-1:0] acc_total, acc_rnd;
    logic signed [XW:0] v_rnd;
    logic signed [XW-8:0] out_full;
    slfc_pkg::sample_t out_sat;
    logic [WW-1:0]    lp_a, tp_a, one_minus_tp;
    state_t           after_kalman, after_lowpass;

    assign cur_est = est_reg[ch_reg];
    assign cur_y   = y_reg[ch_reg];
    assign cur_x1  = x1_reg[ch_reg];
    assign cur_x2  = x2_reg[ch_reg];
    assign v24     = v_reg[LW-1:0];

    assign lp_a         = slfc_pkg::clamp_weight(lp_alpha_reg);
    assign tp_a         = slfc_pkg::clamp_weight(tp_alpha_reg);
    assign one_minus_tp = slfc_pkg::ONE_Q16 - tp_a;

    assign pp_sum  = {1'b0, p_reg[ch_reg]} + {1'b0, q_reg};
    assign den_sum = {1'b0, pp_reg} + {1'b0, r_reg};
    assign rem_sh  = {rem_reg, 1'b0};
    assign rem_sub = rem_sh - {1'b0, den_reg};
    assign div_ge  = (rem_sh >= {1'b0, den_reg});

    // Round half up: add half an LSB and shift arithmetically.
    assign prod_rnd = product + PW'(32768);
    assign rnd16    = prod_rnd[PW-1:16];
    assign p_rnd    = product + PW'(32768);

    assign diff_est = {v24[LW-1], v24} - {cur_est[LW-1], cur_est};
    assign diff_y   = {v24[LW-1], v24} - {cur_y[LW-1], cur_y};
    assign est_sum  = {cur_est[LW-1], cur_est} + rnd16[LW:0];
    assign y_sum    = {cur_y[LW-1], cur_y} + rnd16[LW:0];

    assign acc_total = acc_reg + product[AW-1:0];
    assign acc_rnd   = acc_total + AW'(32768);

    assign v_rnd    = {v_reg[XW-1], v_reg} + (XW+1)'(128);
    assign out_full = v_rnd[XW:8];

    always_comb
    begin
        if (out_full > (XW-7)'(32767))
            out_sat = 16'sh7FFF;
        else if (out_full < -(XW-7)'(32768))
            out_sat = 16'sh8000;
        else
            out_sat = out_full[15:0];
    end

    always_comb
    begin
        if (en_lp_reg)
            after_kalman = ST_LP1;
        else if (en_tp_reg)
            after_kalman = ST_SW1;
        else
            after_kalman = ST_OUT;
        after_lowpass = en_tp_reg ? ST_SW1 : ST_OUT;
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_KM1:
            begin
                mul_a = {1'b0, k_reg};
                mul_b = 34'(diff_est);
            end
            ST_KM2:
            begin
                mul_a = {1'b0, 17'(slfc_pkg::ONE_Q16 - k_reg)};
                mul_b = {2'b00, pp_reg};
            end
            ST_LP1:
            begin
                mul_a = {1'b0, lp_a};
                mul_b = 34'(diff_y);
            end
            ST_SW1:
            begin
                mul_a = {1'b0, tp_a};
                mul_b = {17'd0, one_minus_tp};
            end
            ST_SW2:
            begin
                mul_a = {1'b0, rnd16[WW-1:0]};
                mul_b = {17'd0, one_minus_tp};
            end
            ST_SW3:
            begin
                mul_a = {1'b0, tp_a};
                mul_b = 34'(v24);
            end
            ST_SA1:
            begin
                mul_a = {1'b0, w1_reg};
                mul_b = 34'(cur_x1);
            end
            ST_SA2:
            begin
                mul_a = {1'b0, w2_reg};
                mul_b = 34'(cur_x2);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    slfc_mul u_mul (
        .clk     (clk),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .product (product)
    );

    assign samples.ready         = (state_reg == ST_IDLE);
    assign levels.valid          = out_valid_reg;
    assign levels.filtered_level = out_level_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            en_k_reg      <= 1'b1;
            en_lp_reg     <= 1'b1;
            en_tp_reg     <= 1'b0;
            q_reg         <= 32'd168;
            r_reg         <= 32'd1677722;
            lp_alpha_reg  <= 17'd36497;
            tp_alpha_reg  <= 17'd36497;
            for (int i = 0; i < slfc_pkg::NUM_CHANNELS; i++)
            begin
                est_reg[i] <= '0;
                p_reg[i]   <= '0;
                y_reg[i]   <= '0;
                x1_reg[i]  <= '0;
                x2_reg[i]  <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    slfc_pkg::REG_ENABLE_KALMAN:   en_k_reg     <= cfg_data[0];
                    slfc_pkg::REG_ENABLE_LOWPASS:  en_lp_reg    <= cfg_data[0];
                    slfc_pkg::REG_ENABLE_TWO_POLE: en_tp_reg    <= cfg_data[0];
                    slfc_pkg::REG_PROCESS_NOISE:   q_reg        <= cfg_data;
                    slfc_pkg::REG_MEAS_NOISE:      r_reg        <= cfg_data;
                    slfc_pkg::REG_LOWPASS_ALPHA:   lp_alpha_reg <= cfg_data[WW-1:0];
                    slfc_pkg::REG_TWO_POLE_ALPHA:  tp_alpha_reg <= cfg_data[WW-1:0];
                    default:                       ;
                endcase
            end

            // In the output state the state machine itself owns the output valid.
            if (out_valid_reg && levels.ready && state_reg != ST_OUT)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (samples.valid)
                    begin
                        ch_reg <= samples.channel;
                        v_reg  <= XW'(slfc_pkg::level_t'({samples.sample_level, 8'd0}));
                        if (en_k_reg)
                            state_reg <= ST_KPP;
                        else if (en_lp_reg)
                            state_reg <= ST_LP1;
                        else if (en_tp_reg)
                            state_reg <= ST_SW1;
                        else
                            state_reg <= ST_OUT;
                    end
                end
                ST_KPP:
                begin
                    pp_reg    <= pp_sum[VW] ? {VW{1'b1}} : pp_sum[VW-1:0];
                    state_reg <= ST_KDEN;
                end
                ST_KDEN:
                begin
                    den_reg   <= den_sum;
                    state_reg <= ST_KDIVI;
                end
                ST_KDIVI:
                begin
                    cnt_reg <= '0;
                    if (den_reg == '0)
                    begin
                        k_reg     <= '0;
                        state_reg <= ST_KM1;
                    end
                    else if ({1'b0, pp_reg} >= den_reg)
                    begin
                        k_reg     <= WW'(1);
                        rem_reg   <= {1'b0, pp_reg} - den_reg;
                        state_reg <= ST_KDIV;
                    end
                    else
                    begin
                        k_reg     <= '0;
                        rem_reg   <= {1'b0, pp_reg};
                        state_reg <= ST_KDIV;
                    end
                end
                ST_KDIV:
                begin
                    // One quotient bit per cycle; the remainder stays below the denominator.
                    k_reg   <= {k_reg[WW-2:0], div_ge};
                    rem_reg <= div_ge ? rem_sub[VW:0] : rem_sh[VW:0];
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg == 4'd15)
                        state_reg <= ST_KM1;
                end
                ST_KM1:
                    state_reg <= ST_KM2;
                ST_KM2:
                begin
                    est_reg[ch_reg] <= est_sum[LW-1:0];
                    v_reg           <= XW'(slfc_pkg::level_t'(est_sum[LW-1:0]));
                    state_reg       <= ST_KM3;
                end
                ST_KM3:
                begin
                    p_reg[ch_reg] <= p_rnd[VW+15:16];
                    state_reg     <= after_kalman;
                end
                ST_LP1:
                    state_reg <= ST_LP2;
                ST_LP2:
                begin
                    y_reg[ch_reg] <= y_sum[LW-1:0];
                    v_reg         <= XW'(slfc_pkg::level_t'(y_sum[LW-1:0]));
                    state_reg     <= after_lowpass;
                end
                ST_SW1:
                    state_reg <= ST_SW2;
                ST_SW2:
                begin
                    w1_reg    <= rnd16[WW-1:0];
                    state_reg <= ST_SW3;
                end
                ST_SW3:
                begin
                    w2_reg    <= rnd16[WW-1:0];
                    state_reg <= ST_SA1;
                end
                ST_SA1:
                begin
                    acc_reg   <= product[AW-1:0];
                    state_reg <= ST_SA2;
                end
                ST_SA2:
                begin
                    acc_reg   <= acc_total;
                    state_reg <= ST_SA3;
                end
                ST_SA3:
                begin
                    x2_reg[ch_reg] <= cur_x1;
                    x1_reg[ch_reg] <= v24;
                    v_reg          <= acc_rnd[XW+15:16];
                    state_reg      <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (!out_valid_reg || levels.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_level_reg <= out_sat;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire
